// ===== hw/rtl/u16550_pkg.sv =====
// Shared constants, types and register codes for the 16550 register block.
`timescale 1ns / 1ps

package u16550_pkg;

    // FIFO geometry; every pointer and count width is derived from the depth.
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = PTR_W + 1;

    // Kinds of transaction on the input channel.
    typedef enum logic [1:0] {
        REQ_BUS_READ  = 2'd0,
        REQ_BUS_WRITE = 2'd1,
        REQ_RX_BYTE   = 2'd2,
        REQ_TX_TICK   = 2'd3
    } req_type_t;

    // Register offsets from the port base.
    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_FCR  = 3'd2;
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    // Register bit fields.
    localparam int         LCR_DLAB_BIT     = 7;
    localparam logic [7:0] IIR_NONE         = 8'h01;
    localparam logic [7:0] IIR_FIFO_BITS    = 8'hC0;
    localparam int         FCR_ENABLE_BIT   = 0;
    localparam int         FCR_CLEAR_RX_BIT = 1;
    localparam int         FCR_CLEAR_TX_BIT = 2;
    localparam logic [7:0] LSR_DR           = 8'h01;
    localparam logic [7:0] LSR_OE           = 8'h02;
    localparam logic [7:0] LSR_THRE         = 8'h20;
    localparam logic [7:0] LSR_TEMT         = 8'h40;
    localparam int         IER_W            = 4;
    localparam int         MCR_W            = 5;

endpackage

// ===== hw/rtl/u16550_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module u16550_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/uart_16550_register_block_top.sv =====
// Top level of the 16550 register block: register file, FIFO control and output stage.
`timescale 1ns / 1ps

// Usage. Every input transaction is one of four kinds: a bus read or a bus
// write at one of eight register offsets, a byte received from the serial
// line, or a transmitter-ready tick. Every input transaction produces exactly
// one output transaction carrying read_byte (the register value of a bus read,
// zero otherwise) and send_valid/send_byte (a byte leaving the transmit FIFO).
// Bit 7 of LCR maps offsets 0 and 1 onto the divisor latches.
// Each result passes through the read stage, which waits for the registered
// FIFO RAM read data, and then the output register before it is offered.
// Throughput is one transaction per cycle while the output is not stalled:
// control registers and FIFO pointers update in the acceptance cycle, so the
// next transaction sees them at once, and a push written in one cycle is
// readable by a pop in the next.
// When the receiver stalls, the result waits in the output register while one
// more transaction is accepted into the read stage; s_ready then drops until
// the output register drains. The RAM read data holds meanwhile because no
// new read is issued. Reset clears the control registers, pointers, counts and
// valid flags; the FIFO RAM contents are never cleared, since only counted
// entries are read.

module uart_16550_register_block_top
    import u16550_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [2:0] s_reg_offset,
    input  logic [7:0] s_write_byte,
    input  logic [7:0] s_line_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic       m_send_valid,
    output logic [7:0] m_send_byte
);

    // Architectural registers. The FCR trigger level field has no consumer
    // here because interrupt generation is outside this block, so it is not held.
    logic [7:0]       lcr_reg, lcr_next;
    logic [IER_W-1:0] ier_reg, ier_next;
    logic [MCR_W-1:0] mcr_reg, mcr_next;
    logic [7:0]       scr_reg, scr_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic             fifo_en_reg, fifo_en_next;
    logic             overrun_reg, overrun_next;

    // FIFO pointers; the data itself lives in the two RAMs.
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [CNT_W-1:0] tx_count_reg, tx_count_next;

    // Read stage: holds the transaction while the registered RAM read data arrives.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_read_reg, s1_read_next;
    logic       s1_rx_pop_reg, s1_rx_pop_next;
    logic       s1_send_reg, s1_send_next;

    // Output stage.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_read_reg, m_read_next;
    logic       m_send_valid_reg, m_send_valid_next;
    logic [7:0] m_send_byte_reg, m_send_byte_next;

    // RAM ports.
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [PTR_W-1:0] rx_waddr, tx_waddr;
    logic [7:0]       rx_wdata, tx_wdata;
    logic [7:0]       rx_rdata, tx_rdata;

    logic      advance_out;
    logic      accept;
    logic      dlab;
    logic      rx_full, tx_full, rx_empty, tx_empty;
    req_type_t req;

    function automatic logic [PTR_W-1:0] tail_addr(input logic [PTR_W-1:0] head,
                                                   input logic [CNT_W-1:0] count);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(count);
        if (sum >= SUM_W'(FIFO_DEPTH)) begin
            sum = sum - SUM_W'(FIFO_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] next_addr(input logic [PTR_W-1:0] head);
        logic [PTR_W-1:0] nxt;
        if (head == PTR_W'(FIFO_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + PTR_W'(1);
        end
        return nxt;
    endfunction

    // A new transaction enters whenever the read stage is empty or moves on.
    assign advance_out = !m_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || advance_out;
    assign accept      = s_valid && s_ready;

    assign req      = req_type_t'(s_req_type);
    assign dlab     = lcr_reg[LCR_DLAB_BIT];
    assign rx_full  = (rx_count_reg == CNT_W'(FIFO_DEPTH));
    assign tx_full  = (tx_count_reg == CNT_W'(FIFO_DEPTH));
    assign rx_empty = (rx_count_reg == '0);
    assign tx_empty = (tx_count_reg == '0);

    assign rx_waddr = tail_addr(rx_head_reg, rx_count_reg);
    assign tx_waddr = tail_addr(tx_head_reg, tx_count_reg);
    assign rx_wdata = s_line_byte;
    assign tx_wdata = s_write_byte;

    always_comb begin
        lcr_next      = lcr_reg;
        ier_next      = ier_reg;
        mcr_next      = mcr_reg;
        scr_next      = scr_reg;
        dll_next      = dll_reg;
        dlm_next      = dlm_reg;
        fifo_en_next  = fifo_en_reg;
        overrun_next  = overrun_reg;
        rx_head_next  = rx_head_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_count_next = tx_count_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        s1_read_next   = '0;
        s1_rx_pop_next = 1'b0;
        s1_send_next   = 1'b0;

        if (accept) begin
            unique case (req)
                REQ_BUS_READ: begin
                    unique case (s_reg_offset)
                        OFF_DATA: begin
                            if (dlab) begin
                                s1_read_next = dll_reg;
                            end else if (!rx_empty) begin
                                // The popped byte arrives from the RAM next cycle.
                                rx_re          = 1'b1;
                                s1_rx_pop_next = 1'b1;
                                rx_head_next   = next_addr(rx_head_reg);
                                rx_count_next  = rx_count_reg - CNT_W'(1);
                            end
                        end
                        OFF_IER: begin
                            s1_read_next = dlab ? dlm_reg : 8'(ier_reg);
                        end
                        OFF_FCR: begin
                            s1_read_next = IIR_NONE | (fifo_en_reg ? IIR_FIFO_BITS : 8'h00);
                        end
                        OFF_LCR: s1_read_next = lcr_reg;
                        OFF_MCR: s1_read_next = 8'(mcr_reg);
                        OFF_LSR: begin
                            // Overrun is reported as it stood, then cleared by the read.
                            s1_read_next = (rx_empty ? 8'h00 : LSR_DR) |
                                           (overrun_reg ? LSR_OE : 8'h00) |
                                           (tx_empty ? (LSR_THRE | LSR_TEMT) : 8'h00);
                            overrun_next = 1'b0;
                        end
                        OFF_MSR: s1_read_next = 8'h00;
                        OFF_SCR: s1_read_next = scr_reg;
                        default: s1_read_next = 8'h00;
                    endcase
                end
                REQ_BUS_WRITE: begin
                    unique case (s_reg_offset)
                        OFF_DATA: begin
                            if (dlab) begin
                                dll_next = s_write_byte;
                            end else if (!tx_full) begin
                                tx_we         = 1'b1;
                                tx_count_next = tx_count_reg + CNT_W'(1);
                            end
                        end
                        OFF_IER: begin
                            if (dlab) begin
                                dlm_next = s_write_byte;
                            end else begin
                                ier_next = s_write_byte[IER_W-1:0];
                            end
                        end
                        OFF_FCR: begin
                            fifo_en_next = s_write_byte[FCR_ENABLE_BIT];
                            if (s_write_byte[FCR_CLEAR_RX_BIT]) begin
                                rx_head_next  = '0;
                                rx_count_next = '0;
                            end
                            if (s_write_byte[FCR_CLEAR_TX_BIT]) begin
                                tx_head_next  = '0;
                                tx_count_next = '0;
                            end
                        end
                        OFF_LCR: lcr_next = s_write_byte;
                        OFF_MCR: mcr_next = s_write_byte[MCR_W-1:0];
                        OFF_SCR: scr_next = s_write_byte;
                        default: begin
                        end
                    endcase
                end
                REQ_RX_BYTE: begin
                    if (rx_full) begin
                        overrun_next = 1'b1;
                    end else begin
                        rx_we         = 1'b1;
                        rx_count_next = rx_count_reg + CNT_W'(1);
                    end
                end
                REQ_TX_TICK: begin
                    if (!tx_empty) begin
                        tx_re         = 1'b1;
                        s1_send_next  = 1'b1;
                        tx_head_next  = next_addr(tx_head_reg);
                        tx_count_next = tx_count_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline stage control.
    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance_out) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next      = m_valid_reg;
        m_read_next       = m_read_reg;
        m_send_valid_next = m_send_valid_reg;
        m_send_byte_next  = m_send_byte_reg;
        if (advance_out) begin
            m_valid_next      = s1_valid_reg;
            m_read_next       = s1_rx_pop_reg ? rx_rdata : s1_read_reg;
            m_send_valid_next = s1_send_reg;
            m_send_byte_next  = s1_send_reg ? tx_rdata : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcr_reg      <= '0;
            ier_reg      <= '0;
            mcr_reg      <= '0;
            scr_reg      <= '0;
            dll_reg      <= '0;
            dlm_reg      <= '0;
            fifo_en_reg  <= 1'b0;
            overrun_reg  <= 1'b0;
            rx_head_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_count_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            lcr_reg      <= lcr_next;
            ier_reg      <= ier_next;
            mcr_reg      <= mcr_next;
            scr_reg      <= scr_next;
            dll_reg      <= dll_next;
            dlm_reg      <= dlm_next;
            fifo_en_reg  <= fifo_en_next;
            overrun_reg  <= overrun_next;
            rx_head_reg  <= rx_head_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_count_reg <= tx_count_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_reg   <= s1_read_next;
            s1_rx_pop_reg <= s1_rx_pop_next;
            s1_send_reg   <= s1_send_next;
        end
        m_read_reg       <= m_read_next;
        m_send_valid_reg <= m_send_valid_next;
        m_send_byte_reg  <= m_send_byte_next;
    end

    u16550_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    u16550_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (tx_re),
        .raddr (tx_head_reg),
        .rdata (tx_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_read_byte  = m_read_reg;
    assign m_send_valid = m_send_valid_reg;
    assign m_send_byte  = m_send_byte_reg;

`ifndef NO_ASSERTIONS
    a_rx_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("receive FIFO count exceeds its depth");

    a_tx_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("transmit FIFO count exceeds its depth");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rx_re && rx_empty) && !(tx_re && tx_empty))
        else $error("FIFO RAM read issued while the FIFO is empty");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled while the pipeline has room");

    a_rdata_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_rx_pop_reg && !advance_out) |=> $stable(rx_rdata))
        else $error("receive RAM data changed while its pop waits in the read stage");
`endif

endmodule

// ===== sim/tb_uart_16550_register_block_top.sv =====
// Self-checking testbench for the 16550 register block: bus, line and FIFO traffic.
`timescale 1ns / 1ps

module tb_uart_16550_register_block_top;
    import u16550_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_IDLE        = 13;

    localparam logic [7:0] LCR_DLAB_SET   = 8'(1 << LCR_DLAB_BIT);
    localparam logic [7:0] FCR_ENABLE     = 8'(1 << FCR_ENABLE_BIT);
    localparam logic [7:0] FCR_CLEAR_BOTH = 8'((1 << FCR_CLEAR_RX_BIT) |
                                               (1 << FCR_CLEAR_TX_BIT));

    // One output transaction of the block.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       send_valid;
        logic [7:0] send_byte;
    } uart_result_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    req_type_t  s_req_type;
    logic [2:0] s_reg_offset;
    logic [7:0] s_write_byte;
    logic [7:0] s_line_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_read_byte;
    logic       m_send_valid;
    logic [7:0] m_send_byte;

    // Shadow copy of the register file and both FIFOs. The FCR trigger level
    // has no visible effect, so it is not mirrored.
    logic [7:0]       div_low      = '0;
    logic [7:0]       div_high     = '0;
    logic [IER_W-1:0] irq_en       = '0;
    logic [7:0]       line_ctrl    = '0;
    logic [MCR_W-1:0] modem_ctrl   = '0;
    logic [7:0]       scratch_reg  = '0;
    logic             fifo_on      = 1'b0;
    logic             overrun      = 1'b0;
    logic [7:0]       rx_mem [FIFO_DEPTH];
    logic [7:0]       tx_mem [FIFO_DEPTH];
    int               rx_head      = 0;
    int               rx_level     = 0;
    int               tx_head      = 0;
    int               tx_level     = 0;

    uart_result_t     pending_results [$];
    int unsigned      requests_sent = 0;
    int unsigned      results_seen  = 0;
    int unsigned      error_count   = 0;
    int unsigned      req_gap_max   = 0;
    int unsigned      rsp_stall_max = 0;
    int unsigned      stall_left    = 0;
    int unsigned      idle_cycles   = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    uart_16550_register_block_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_reg_offset (s_reg_offset),
        .s_write_byte (s_write_byte),
        .s_line_byte  (s_line_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_byte  (m_read_byte),
        .m_send_valid (m_send_valid),
        .m_send_byte  (m_send_byte)
    );

    task automatic report_mismatch(input string what, input int unsigned got_val,
                                   input int unsigned want_val);
        $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got_val,
                 want_val);
        error_count++;
    endtask

    // Applies one request to the shadow state and returns the transaction the
    // block must produce for it.
    function automatic uart_result_t predict_uart_result(input req_type_t req,
                                                         input logic [2:0] off,
                                                         input logic [7:0] wdata,
                                                         input logic [7:0] ldata);
        uart_result_t r;
        logic         dlab;
        r    = '0;
        dlab = line_ctrl[LCR_DLAB_BIT];
        case (req)
            REQ_BUS_READ: begin
                case (off)
                    OFF_DATA: begin
                        if (dlab) begin
                            r.read_byte = div_low;
                        end else if (rx_level != 0) begin
                            r.read_byte = rx_mem[PTR_W'(rx_head)];
                            rx_head     = (rx_head + 1) % FIFO_DEPTH;
                            rx_level--;
                        end
                    end
                    OFF_IER: r.read_byte = dlab ? div_high : 8'(irq_en);
                    OFF_FCR: r.read_byte = IIR_NONE | (fifo_on ? IIR_FIFO_BITS : 8'h00);
                    OFF_LCR: r.read_byte = line_ctrl;
                    OFF_MCR: r.read_byte = 8'(modem_ctrl);
                    OFF_LSR: begin
                        // The overrun flag is reported once, then cleared by the read.
                        r.read_byte = ((rx_level != 0) ? LSR_DR : 8'h00) |
                                      (overrun ? LSR_OE : 8'h00) |
                                      ((tx_level == 0) ? (LSR_THRE | LSR_TEMT) : 8'h00);
                        overrun = 1'b0;
                    end
                    OFF_SCR: r.read_byte = scratch_reg;
                    default: ;
                endcase
            end
            REQ_BUS_WRITE: begin
                case (off)
                    OFF_DATA: begin
                        if (dlab) begin
                            div_low = wdata;
                        end else if (tx_level < FIFO_DEPTH) begin
                            tx_mem[PTR_W'((tx_head + tx_level) % FIFO_DEPTH)] = wdata;
                            tx_level++;
                        end
                    end
                    OFF_IER: begin
                        if (dlab) div_high = wdata;
                        else      irq_en   = wdata[IER_W-1:0];
                    end
                    OFF_FCR: begin
                        fifo_on = wdata[FCR_ENABLE_BIT];
                        if (wdata[FCR_CLEAR_RX_BIT]) begin
                            rx_head  = 0;
                            rx_level = 0;
                        end
                        if (wdata[FCR_CLEAR_TX_BIT]) begin
                            tx_head  = 0;
                            tx_level = 0;
                        end
                    end
                    OFF_LCR: line_ctrl   = wdata;
                    OFF_MCR: modem_ctrl  = wdata[MCR_W-1:0];
                    OFF_SCR: scratch_reg = wdata;
                    default: ;
                endcase
            end
            REQ_RX_BYTE: begin
                if (rx_level < FIFO_DEPTH) begin
                    rx_mem[PTR_W'((rx_head + rx_level) % FIFO_DEPTH)] = ldata;
                    rx_level++;
                end else begin
                    overrun = 1'b1;
                end
            end
            default: begin
                if (tx_level != 0) begin
                    r.send_valid = 1'b1;
                    r.send_byte  = tx_mem[PTR_W'(tx_head)];
                    tx_head      = (tx_head + 1) % FIFO_DEPTH;
                    tx_level--;
                end
            end
        endcase
        return r;
    endfunction

    // Checks each result against the oldest expectation, predicts each
    // accepted request, and stalls the result channel at random.
    always @(posedge aclk) begin : result_scoreboard
        uart_result_t want;
        int unsigned  stall;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(m_read_byte), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_read_byte !== want.read_byte)
                        report_mismatch("read_byte", 32'(m_read_byte),
                                        32'(want.read_byte));
                    if (m_send_valid !== want.send_valid)
                        report_mismatch("send_valid", 32'(m_send_valid),
                                        32'(want.send_valid));
                    if (m_send_byte !== want.send_byte)
                        report_mismatch("send_byte", 32'(m_send_byte),
                                        32'(want.send_byte));
                end
                stall = $urandom_range(rsp_stall_max, 0);
                stall_left <= stall;
                m_ready    <= (stall == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= (stall_left == 1);
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_uart_result(s_req_type, s_reg_offset,
                                                              s_write_byte, s_line_byte));
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Ends a hung run: no transaction on either channel for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request after a random gap and holds it until accepted.
    // Valid is left high on return so that a back-to-back request needs no
    // second assignment in the same step.
    task automatic send_uart_request(input req_type_t req, input logic [2:0] off,
                                     input logic [7:0] wdata, input logic [7:0] ldata);
        int unsigned gap;
        gap = $urandom_range(req_gap_max, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_reg_offset <= off;
        s_write_byte <= wdata;
        s_line_byte  <= ldata;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic send_bus_read(input logic [2:0] off);
        send_uart_request(REQ_BUS_READ, off, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_bus_write(input logic [2:0] off, input logic [7:0] data);
        send_uart_request(REQ_BUS_WRITE, off, data, 8'($urandom));
    endtask

    task automatic send_line_byte(input logic [7:0] data);
        send_uart_request(REQ_RX_BYTE, 3'($urandom), 8'($urandom), data);
    endtask

    task automatic send_tx_tick();
        send_uart_request(REQ_TX_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stops offering requests until every expected result has come back.
    task automatic drain_pending_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_seen != requests_sent);
    endtask

    task automatic test_reset_values();
        req_gap_max   = 0;
        rsp_stall_max = 0;
        send_bus_read(OFF_LSR);
        send_bus_read(OFF_FCR);
        send_bus_read(OFF_MSR);
    endtask

    task automatic test_register_map();
        req_gap_max   = MAX_IDLE;
        rsp_stall_max = MAX_IDLE;
        // Only the implemented bits of IER and MCR must read back.
        send_bus_write(OFF_IER, 8'hFF);
        send_bus_read(OFF_IER);
        send_bus_write(OFF_MCR, 8'hFF);
        send_bus_read(OFF_MCR);
        send_bus_write(OFF_SCR, 8'hA5);
        send_bus_read(OFF_SCR);
        // With DLAB set, offsets 0 and 1 reach the divisor latches.
        send_bus_write(OFF_LCR, 8'hFF);
        send_bus_write(OFF_DATA, 8'hFF);
        send_bus_write(OFF_IER, 8'h00);
        send_bus_read(OFF_DATA);
        send_bus_read(OFF_IER);
        send_bus_write(OFF_LCR, 8'h00);
        send_bus_write(OFF_FCR, IIR_FIFO_BITS | FCR_ENABLE);
        send_bus_read(OFF_FCR);
        // Writes to the status registers have no effect.
        send_bus_write(OFF_LSR, 8'hFF);
        send_bus_write(OFF_MSR, 8'hFF);
    endtask

    task automatic test_fifo_corners();
        req_gap_max   = 0;
        rsp_stall_max = MAX_IDLE;
        send_bus_read(OFF_DATA);           // empty receive read
        send_tx_tick();                    // tick with nothing to send
        send_bus_write(OFF_DATA, 8'h00);
        send_tx_tick();
        send_line_byte(8'hFF);
        send_bus_read(OFF_LSR);
        send_bus_read(OFF_DATA);
        // FCR clear bits empty both FIFOs even with FIFO mode off.
        send_line_byte(8'h5A);
        send_bus_write(OFF_DATA, 8'h3C);
        send_bus_write(OFF_FCR, FCR_CLEAR_BOTH);
        send_bus_read(OFF_LSR);
    endtask

    // Fills both FIFOs past their depth, lets the block go idle, then checks
    // that overrun is reported once and that the dropped bytes stay dropped.
    task automatic test_fifo_overflow();
        int i;
        req_gap_max   = 0;
        rsp_stall_max = 0;
        for (i = 0; i <= FIFO_DEPTH; i++) begin
            send_line_byte(8'($urandom));
            send_bus_write(OFF_DATA, 8'($urandom));
        end
        drain_pending_results();
        req_gap_max   = MAX_IDLE;
        rsp_stall_max = MAX_IDLE;
        send_bus_read(OFF_LSR);
        send_bus_read(OFF_LSR);
        for (i = 0; i <= FIFO_DEPTH; i++) begin
            send_tx_tick();
            send_bus_read(OFF_DATA);
        end
        send_bus_read(OFF_LSR);
    endtask

    // Random sequences: FIFO bursts, register round trips, divisor access,
    // FCR writes and unstructured noise, each under its own idling pattern.
    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned pace;
        int          n;
        int          m;
        int          i;
        logic [2:0]  off;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS) begin
            pace          = $urandom_range(3, 0);
            req_gap_max   = pace[0] ? MAX_IDLE : 0;
            rsp_stall_max = pace[1] ? MAX_IDLE : 0;
            case ($urandom_range(5, 0))
                0: begin
                    send_bus_write(OFF_LCR, 8'($urandom) & ~LCR_DLAB_SET);
                    n = $urandom_range(FIFO_DEPTH + 4, 1);
                    for (i = 0; i < n; i++) begin
                        send_line_byte(8'($urandom));
                        if ($urandom_range(5, 0) == 0) send_bus_read(OFF_LSR);
                    end
                    m = $urandom_range(n + 2, 0);
                    for (i = 0; i < m; i++)
                        send_bus_read(($urandom_range(3, 0) == 0) ? OFF_LSR : OFF_DATA);
                end
                1: begin
                    send_bus_write(OFF_LCR, 8'($urandom) & ~LCR_DLAB_SET);
                    n = $urandom_range(FIFO_DEPTH + 4, 1);
                    for (i = 0; i < n; i++) begin
                        send_bus_write(OFF_DATA, 8'($urandom));
                        if ($urandom_range(7, 0) == 0) send_line_byte(8'($urandom));
                    end
                    m = $urandom_range(n + 2, 0);
                    for (i = 0; i < m; i++) begin
                        if ($urandom_range(3, 0) == 0) send_bus_read(OFF_LSR);
                        else                           send_tx_tick();
                    end
                end
                2: begin
                    off = 3'($urandom);
                    send_bus_write(off, 8'($urandom));
                    send_bus_read(off);
                end
                3: begin
                    send_bus_write(OFF_LCR, 8'($urandom) | LCR_DLAB_SET);
                    send_bus_write(OFF_DATA, 8'($urandom));
                    send_bus_write(OFF_IER, 8'($urandom));
                    send_bus_read(OFF_DATA);
                    send_bus_read(OFF_IER);
                    send_bus_read(OFF_LCR);
                    send_bus_write(OFF_LCR, 8'($urandom) & ~LCR_DLAB_SET);
                end
                4: begin
                    send_bus_write(OFF_FCR, 8'($urandom));
                    send_bus_read(OFF_FCR);
                    send_bus_read(OFF_LSR);
                end
                default: begin
                    n = $urandom_range(8, 1);
                    for (i = 0; i < n; i++) begin
                        send_uart_request(req_type_t'(2'($urandom_range(3, 0))),
                                          3'($urandom), 8'($urandom), 8'($urandom));
                    end
                end
            endcase
            if ($urandom_range(11, 0) == 0) drain_pending_results();
        end
    endtask

    initial begin : test_sequence
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_BUS_READ;
        s_reg_offset <= OFF_DATA;
        s_write_byte <= '0;
        s_line_byte  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_map();
        test_fifo_corners();
        test_fifo_overflow();
        test_random_traffic();

        // Wait for the last results, then give the pipeline time to show any
        // transaction that nobody asked for.
        drain_pending_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("expected results never arrived",
                            32'(pending_results.size()), 0);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
